// ===== hw/rtl/wmc_pkg.sv =====
// ----------------------------------------------------------------------------
// wmc_pkg
// Types, constants and helpers shared by the watering button mode controller.
// ----------------------------------------------------------------------------
package wmc_pkg;

  // Counter and register widths
  localparam int CNT_W = 32;
  localparam int CFG_W = 32;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Border value applied at reset
  localparam logic [7:0] BORDER_RST = 8'd50;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_INIT_BORDER   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WATERING      = 3'd1;
  localparam logic [IDX_W-1:0] REG_UPDATE_PERIOD = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOUNCE_MAX    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CLICK_MAX     = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOLD_MAX      = 3'd5;
  localparam logic [IDX_W-1:0] REG_BLINK         = 3'd6;
  localparam logic [IDX_W-1:0] REG_REPORT_PERIOD = 3'd7;

  // Register reset values
  localparam logic [CFG_W-1:0] WATERING_RST      = 32'd46000;
  localparam logic [CFG_W-1:0] UPDATE_PERIOD_RST = 32'd993600000;
  localparam logic [CFG_W-1:0] BOUNCE_MAX_RST    = 32'd230;
  localparam logic [CFG_W-1:0] CLICK_MAX_RST     = 32'd16100;
  localparam logic [CFG_W-1:0] HOLD_MAX_RST      = 32'd69000;
  localparam logic [CFG_W-1:0] BLINK_RST         = 32'd230;
  localparam logic [CFG_W-1:0] REPORT_PERIOD_RST = 32'd23000;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_BLINK = 3'd1,
    MODE_WATER = 3'd2,
    MODE_MEAS  = 3'd3,
    MODE_FLASH = 3'd4,
    MODE_PRESS = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    KIND_DRY      = 3'd0,
    KIND_WET      = 3'd1,
    KIND_BORDER   = 3'd2,
    KIND_MEAS     = 3'd3,
    KIND_PERIODIC = 3'd4
  } kind_e;

  typedef struct packed {
    logic [CFG_W-1:0] watering;
    logic [CFG_W-1:0] update_period;
    logic [CFG_W-1:0] bounce_max;
    logic [CFG_W-1:0] click_max;
    logic [CFG_W-1:0] hold_max;
    logic [CFG_W-1:0] blink;
    logic [CFG_W-1:0] report_period;
  } cfg_t;

  typedef struct packed {
    logic       pump_drive;
    logic       led_drive;
    logic       report_valid;
    kind_e      report_kind;
    logic [7:0] report_value;
    mode_e      mode;
  } step_res_t;

  // Saturating increment of a tick counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
    return (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
  endfunction

  // Counter reached a register limit
  function automatic logic cnt_ge(input logic [CNT_W-1:0] cnt,
                                  input logic [CFG_W-1:0] lim);
    return CMP_W'(cnt) >= CMP_W'(lim);
  endfunction

endpackage

// ===== hw/rtl/watering_button_mode_controller.sv =====
// ----------------------------------------------------------------------------
// watering_button_mode_controller
// Button-driven watering controller: one input transaction per timer tick,
// one result transaction per input.
//
//   channel   | direction | contents
//   ----------+-----------+-------------------------------------------------
//   s_axis    | in        | tdata: button_pressed, moisture_sample
//   m_axis    | out       | tdata: pump/led/report/mode, tuser: report_kind
//   cfg       | in        | register write: cfg_we_i, cfg_idx_i, cfg_data_i
//
// One transaction per cycle sustained while m_axis does not stall; each result
// passes through the input register and then the result register after its
// input is accepted.
// The controller state updates once per processed tick, so ticks can follow
// back to back.
// Reset clears all state; the border returns to 50 and registers to defaults.
// A stall on m_axis holds the result register and, once the input register
// is also full, drops s_axis_tready.
// ----------------------------------------------------------------------------
module watering_button_mode_controller import wmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [0] button_pressed, [8:1] moisture_sample
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [0] pump_drive, [1] led_drive,
                                           // [2] report_valid, [10:3] report_value,
                                           // [13:11] mode
  output logic [2:0]       m_axis_tuser,   // [2:0] report_kind
  // configuration
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cfg_t       cfg;
  step_res_t  res;

  logic       in_valid_q;
  logic       btn_q;
  logic [7:0] smp_q;
  logic       out_valid_q;
  step_res_t  out_q;
  logic       out_free;
  logic       step_en;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_en       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  wmc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  wmc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .button_i  (btn_q),
    .sample_i  (smp_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Input register: load on accept, drain on step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (step_en) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      btn_q <= s_axis_tdata[0];
      smp_q <= s_axis_tdata[8:1];
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.mode, out_q.report_value, out_q.report_valid,
                          out_q.led_drive, out_q.pump_drive};
  assign m_axis_tuser  = out_q.report_kind;

endmodule

// ===== hw/rtl/wmc_cfg.sv =====
// ----------------------------------------------------------------------------
// wmc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module wmc_cfg import wmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  // Decode and store register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.watering      <= WATERING_RST;
      cfg_q.update_period <= UPDATE_PERIOD_RST;
      cfg_q.bounce_max    <= BOUNCE_MAX_RST;
      cfg_q.click_max     <= CLICK_MAX_RST;
      cfg_q.hold_max      <= HOLD_MAX_RST;
      cfg_q.blink         <= BLINK_RST;
      cfg_q.report_period <= REPORT_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        // the initial border is reloaded with its reset value by every reset,
        // so a write to it never becomes visible
        REG_INIT_BORDER:   ;
        REG_WATERING:      cfg_q.watering      <= cfg_data_i;
        REG_UPDATE_PERIOD: cfg_q.update_period <= cfg_data_i;
        REG_BOUNCE_MAX:    cfg_q.bounce_max    <= cfg_data_i;
        REG_CLICK_MAX:     cfg_q.click_max     <= cfg_data_i;
        REG_HOLD_MAX:      cfg_q.hold_max      <= cfg_data_i;
        REG_BLINK:         cfg_q.blink         <= cfg_data_i;
        REG_REPORT_PERIOD: cfg_q.report_period <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/wmc_core.sv =====
// ----------------------------------------------------------------------------
// wmc_core
// Controller state and the per-tick update: timers, press classification,
// periodic event. Produces one result per tick.
// ----------------------------------------------------------------------------
module wmc_core import wmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  logic       button_i,
  input  logic [7:0] sample_i,
  input  cfg_t       cfg_i,
  output step_res_t  res_o
);

  mode_e            mode_q, mode_d;
  logic [7:0]       border_q, border_d;
  logic [CNT_W-1:0] period_q, period_d;
  logic [CNT_W-1:0] press_q, press_d;
  logic [CNT_W-1:0] phase_q, phase_d;
  logic             btn_last_q, btn_last_d;

  logic             rv;
  kind_e            rk;
  logic [7:0]       rval;
  mode_e            mode_t;

  // Next state for one tick
  always_comb begin
    period_d   = sat_inc(period_q);
    press_d    = btn_last_q ? sat_inc(press_q) : press_q;
    phase_d    = phase_q;
    border_d   = border_q;
    btn_last_d = btn_last_q;
    mode_t     = mode_q;
    rv         = 1'b0;
    rk         = KIND_DRY;
    rval       = 8'd0;

    // advance timed modes
    case (mode_q)
      MODE_BLINK, MODE_FLASH: begin
        phase_d = sat_inc(phase_q);
        if (cnt_ge(phase_d, cfg_i.blink)) begin
          mode_t = btn_last_q ? MODE_PRESS : MODE_IDLE;
        end
      end
      MODE_WATER: begin
        phase_d = sat_inc(phase_q);
        if (cnt_ge(phase_d, cfg_i.watering)) begin
          mode_t = MODE_IDLE;
        end
      end
      MODE_MEAS: begin
        phase_d = sat_inc(phase_q);
        if (cnt_ge(phase_d, cfg_i.report_period)) begin
          phase_d = '0;
          rv      = 1'b1;
          rk      = KIND_MEAS;
          rval    = sample_i;
        end
      end
      default: ;
    endcase

    mode_d = mode_t;

    // handle a button edge unless the pump runs
    if (mode_t != MODE_WATER && button_i != btn_last_q) begin
      btn_last_d = button_i;
      if (button_i) begin
        press_d = '0;
        phase_d = '0;
        mode_d  = MODE_BLINK;
      end else if (!cnt_ge(press_d, cfg_i.bounce_max)) begin
        mode_d = MODE_IDLE;
      end else if (!cnt_ge(press_d, cfg_i.click_max)) begin
        rv   = 1'b1;
        rval = sample_i;
        if (sample_i > border_q) begin
          rk      = KIND_DRY;
          mode_d  = MODE_WATER;
          phase_d = '0;
        end else begin
          rk     = KIND_WET;
          mode_d = MODE_IDLE;
        end
      end else if (!cnt_ge(press_d, cfg_i.hold_max)) begin
        border_d = sample_i;
        rv       = 1'b1;
        rk       = KIND_BORDER;
        rval     = sample_i;
        mode_d   = MODE_FLASH;
        phase_d  = '0;
      end else begin
        rv      = 1'b1;
        rk      = KIND_MEAS;
        rval    = sample_i;
        mode_d  = MODE_MEAS;
        phase_d = '0;
      end
    end

    // periodic update waits for a free tick outside watering
    if (mode_d != MODE_WATER && !rv && cnt_ge(period_d, cfg_i.update_period)) begin
      period_d = '0;
      rv       = 1'b1;
      rk       = KIND_PERIODIC;
      rval     = sample_i;
      mode_d   = MODE_BLINK;
      phase_d  = '0;
    end
  end

  // Result of the tick
  always_comb begin
    res_o.pump_drive   = (mode_d == MODE_WATER);
    res_o.led_drive    = (mode_d == MODE_BLINK) || (mode_d == MODE_FLASH);
    res_o.report_valid = rv;
    res_o.report_kind  = rv ? rk : KIND_DRY;
    res_o.report_value = rv ? rval : 8'd0;
    res_o.mode         = mode_d;
  end

  // Commit state on each processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      border_q   <= BORDER_RST;
      period_q   <= '0;
      press_q    <= '0;
      phase_q    <= '0;
      btn_last_q <= 1'b0;
    end else if (step_en_i) begin
      mode_q     <= mode_d;
      border_q   <= border_d;
      period_q   <= period_d;
      press_q    <= press_d;
      phase_q    <= phase_d;
      btn_last_q <= btn_last_d;
    end
  end

  // No report while the pump keeps running
  a_water_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && mode_q == MODE_WATER && mode_d == MODE_WATER |-> !rv)
    else $error("report issued during watering");

  // A saved border is the reported value
  a_border_saved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && rv && rk == KIND_BORDER |=> border_q == $past(rval))
    else $error("border not stored");

  // A press edge outside watering starts a blink
  a_press_blink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && button_i && !btn_last_q && mode_t != MODE_WATER
    |=> mode_q == MODE_BLINK && btn_last_q)
    else $error("press edge did not start blink");

  // A periodic report restarts the update timer
  a_period_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && rv && rk == KIND_PERIODIC |=> period_q == '0)
    else $error("update timer not restarted");

endmodule

// ===== dv/watering_button_mode_controller_test.sv =====
// ----------------------------------------------------------------------------
// watering_button_mode_controller_test
// Drives button and moisture ticks through the input stream, including
// bounces, clicks, holds and long holds. Register settings range from short
// timings to the largest values. A tick-level model of the controller behavior
// predicts every result transaction, and each one is checked field by field
// while both streams idle and stall at random.
// ----------------------------------------------------------------------------
module watering_button_mode_controller_test import wmc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CYCLES = 200000;

  typedef logic [7:0][CFG_W-1:0] reg_set_t;

  // Tick model: mirrors the controller state and queues one result per tick
  class tick_scoreboard;
    logic [CFG_W-1:0] regs [8];
    mode_e            mode;
    logic [7:0]       border;
    logic [CNT_W-1:0] since_update;
    logic [CNT_W-1:0] held_for;
    logic [CNT_W-1:0] in_phase;
    logic             btn_last;
    step_res_t        pending [$];
    int               errors;

    function new();
      regs[REG_INIT_BORDER]   = CFG_W'(BORDER_RST);
      regs[REG_WATERING]      = WATERING_RST;
      regs[REG_UPDATE_PERIOD] = UPDATE_PERIOD_RST;
      regs[REG_BOUNCE_MAX]    = BOUNCE_MAX_RST;
      regs[REG_CLICK_MAX]     = CLICK_MAX_RST;
      regs[REG_HOLD_MAX]      = HOLD_MAX_RST;
      regs[REG_BLINK]         = BLINK_RST;
      regs[REG_REPORT_PERIOD] = REPORT_PERIOD_RST;
      mode         = MODE_IDLE;
      border       = BORDER_RST;
      since_update = '0;
      held_for     = '0;
      in_phase     = '0;
      btn_last     = 1'b0;
      errors       = 0;
    endfunction

    // The initial border only matters at reset, so it is merely stored
    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      regs[idx] = (idx == REG_INIT_BORDER) ? (val & CFG_W'(8'hFF)) : val;
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] cnt);
      return (cnt == '1) ? cnt : cnt + 1'b1;
    endfunction

    // Advance one tick and queue the result it produces
    function void note_tick(logic btn, logic [7:0] sample);
      logic       report;
      kind_e      kind;
      logic [7:0] value;
      step_res_t  res;
      report = 1'b0;
      kind   = KIND_DRY;
      value  = '0;

      // Counters and timed modes first
      since_update = bump(since_update);
      if (btn_last)
        held_for = bump(held_for);
      case (mode)
        MODE_BLINK, MODE_FLASH: begin
          in_phase = bump(in_phase);
          if (in_phase >= regs[REG_BLINK])
            mode = btn_last ? MODE_PRESS : MODE_IDLE;
        end
        MODE_WATER: begin
          in_phase = bump(in_phase);
          if (in_phase >= regs[REG_WATERING])
            mode = MODE_IDLE;
        end
        MODE_MEAS: begin
          in_phase = bump(in_phase);
          if (in_phase >= regs[REG_REPORT_PERIOD]) begin
            in_phase = '0;
            report   = 1'b1;
            kind     = KIND_MEAS;
            value    = sample;
          end
        end
        default: ;
      endcase

      // Button edges, not seen while the pump runs
      if (mode != MODE_WATER && btn != btn_last) begin
        btn_last = btn;
        if (btn) begin
          held_for = '0;
          in_phase = '0;
          mode     = MODE_BLINK;
        end else if (held_for < regs[REG_BOUNCE_MAX]) begin
          mode = MODE_IDLE;
        end else if (held_for < regs[REG_CLICK_MAX]) begin
          report = 1'b1;
          value  = sample;
          if (sample > border) begin
            kind     = KIND_DRY;
            mode     = MODE_WATER;
            in_phase = '0;
          end else begin
            kind = KIND_WET;
            mode = MODE_IDLE;
          end
        end else if (held_for < regs[REG_HOLD_MAX]) begin
          border   = sample;
          report   = 1'b1;
          kind     = KIND_BORDER;
          value    = sample;
          mode     = MODE_FLASH;
          in_phase = '0;
        end else begin
          report   = 1'b1;
          kind     = KIND_MEAS;
          value    = sample;
          mode     = MODE_MEAS;
          in_phase = '0;
        end
      end

      // Periodic update, deferred by watering or by another report
      if (mode != MODE_WATER && !report && since_update >= regs[REG_UPDATE_PERIOD]) begin
        since_update = '0;
        report       = 1'b1;
        kind         = KIND_PERIODIC;
        value        = sample;
        mode         = MODE_BLINK;
        in_phase     = '0;
      end

      res.pump_drive   = (mode == MODE_WATER);
      res.led_drive    = (mode == MODE_BLINK || mode == MODE_FLASH);
      res.report_valid = report;
      res.report_kind  = report ? kind : KIND_DRY;
      res.report_value = report ? value : 8'h00;
      res.mode         = mode;
      pending.push_back(res);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Check one result transaction against the oldest prediction
    function void check_result(logic [15:0] data, logic [2:0] user);
      step_res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h/%0h", $time, data, user);
        return;
      end
      want = pending.pop_front();
      compare("pump_drive", 8'(want.pump_drive), 8'(data[0]));
      compare("led_drive", 8'(want.led_drive), 8'(data[1]));
      compare("report_valid", 8'(want.report_valid), 8'(data[2]));
      compare("report_value", want.report_value, data[10:3]);
      compare("mode", 8'(want.mode), 8'(data[13:11]));
      compare("report_kind", 8'(want.report_kind), 8'(user));
    endfunction
  endclass

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata  = '0;   // [0] button_pressed, [8:1] moisture_sample
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;         // [0] pump_drive, [1] led_drive,
                                          // [2] report_valid, [10:3] report_value,
                                          // [13:11] mode
  logic [2:0]       m_axis_tuser;         // [2:0] report_kind
  logic             cfg_we_i      = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0] cfg_data_i    = '0;

  tick_scoreboard score;
  bit             calm        = 1'b0;
  int             ticks_sent  = 0;
  int             cycle_count = 0;

  watering_button_mode_controller u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check accepted results, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      score.check_result(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= calm || ($urandom_range(99) >= 30);
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == MAX_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one tick, with random idle cycles ahead of it
  task automatic send_tick(input logic btn, input logic [7:0] sample);
    while (!calm && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, sample, btn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    score.note_tick(btn, sample);
    ticks_sent++;
  endtask

  // Samples favor the extremes and the values around the border
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return score.border + 8'($urandom_range(2)) - 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Press length, mostly near a class boundary, kept short
  function automatic int press_length();
    longint len;
    case ($urandom_range(3))
      0:       len = longint'(score.regs[REG_BOUNCE_MAX]);
      1:       len = longint'(score.regs[REG_CLICK_MAX]);
      2:       len = longint'(score.regs[REG_HOLD_MAX]);
      default: len = longint'($urandom_range(1, 40));
    endcase
    len = len + longint'($urandom_range(2)) - 1;
    if (len < 1)
      len = 1;
    if (len > 40)
      len = 40;
    return int'(len);
  endfunction

  // Press for the given number of ticks, then release
  task automatic press_button(input int ticks, input logic [7:0] first_s,
                              input logic [7:0] last_s);
    send_tick(1'b1, first_s);
    for (int i = 1; i < ticks; i++)
      send_tick(1'b1, pick_sample());
    send_tick(1'b0, last_s);
  endtask

  task automatic rest(input int ticks);
    repeat (ticks) send_tick(1'b0, pick_sample());
  endtask

  // Hold off until every predicted result has come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (score.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input reg_set_t vals);
    wait_idle();
    for (int i = REG_INIT_BORDER; i <= REG_REPORT_PERIOD; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= IDX_W'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      score.set_reg(IDX_W'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic reg_set_t random_settings();
    reg_set_t v;
    v[REG_INIT_BORDER]   = CFG_W'($urandom_range(255));
    v[REG_WATERING]      = CFG_W'($urandom_range(1, 12));
    v[REG_UPDATE_PERIOD] = CFG_W'($urandom_range(40, 200));
    v[REG_BOUNCE_MAX]    = CFG_W'($urandom_range(4));
    v[REG_CLICK_MAX]     = v[REG_BOUNCE_MAX] + CFG_W'($urandom_range(1, 8));
    v[REG_HOLD_MAX]      = v[REG_CLICK_MAX] + CFG_W'($urandom_range(1, 12));
    v[REG_BLINK]         = CFG_W'($urandom_range(1, 6));
    v[REG_REPORT_PERIOD] = CFG_W'($urandom_range(1, 8));
    return v;
  endfunction

  // Mostly complete presses with random content, some raw button noise
  task automatic run_random(input int budget);
    int stop_at;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        press_button(press_length(), pick_sample(), pick_sample());
        rest(($urandom_range(9) < 8) ? $urandom_range(5) : $urandom_range(6, 24));
      end else begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)), pick_sample());
      end
    end
  endtask

  initial begin
    reg_set_t settings;
    score = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short timings, update timer out of the way
    settings = '1;
    settings[REG_INIT_BORDER]   = CFG_W'(8'd77);
    settings[REG_WATERING]      = 32'd3;
    settings[REG_BOUNCE_MAX]    = 32'd2;
    settings[REG_CLICK_MAX]     = 32'd4;
    settings[REG_HOLD_MAX]      = 32'd5;
    settings[REG_BLINK]         = 32'd1;
    settings[REG_REPORT_PERIOD] = 32'd2;
    apply_settings(settings);
    // bounce
    press_button(1, 8'h00, 8'hFF);
    // dry click, then a level change while the pump runs
    press_button(3, 8'h55, 8'hFF);
    send_tick(1'b1, 8'hFF);
    rest(2);
    // wet click with the sample equal to the border
    press_button(3, 8'hAA, BORDER_RST);
    // hold stores a zero border
    press_button(4, 8'h01, 8'h00);
    // long hold, measurement reports, then a press leaves measuring
    press_button(5, 8'h80, 8'h7F);
    rest(3);
    press_button(1, 8'hFF, 8'h00);

    apply_settings(random_settings());
    run_random(280);

    // No idling on either side for a whole phase
    calm = 1'b1;
    apply_settings(random_settings());
    run_random(280);
    calm = 1'b0;

    // Smallest legal values everywhere
    settings = '0;
    settings[REG_WATERING]      = 32'd1;
    settings[REG_UPDATE_PERIOD] = 32'd1;
    settings[REG_BLINK]         = 32'd1;
    settings[REG_REPORT_PERIOD] = 32'd1;
    apply_settings(settings);
    run_random(250);

    // Largest values: every press is bounce, blinks never end
    settings = '1;
    settings[REG_INIT_BORDER] = CFG_W'(8'hFF);
    apply_settings(settings);
    run_random(150);

    // Every press is a click, with a fast update timer
    settings = random_settings();
    settings[REG_BOUNCE_MAX]    = '0;
    settings[REG_CLICK_MAX]     = '1;
    settings[REG_HOLD_MAX]      = '1;
    settings[REG_UPDATE_PERIOD] = CFG_W'($urandom_range(30, 90));
    apply_settings(settings);
    run_random(300);

    apply_settings(random_settings());
    run_random(300);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (score.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
